// ----- design/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer with burst access.
`default_nettype none

package brb_pkg;

  // Fixed field widths of the streaming words and the length register.
  localparam int LEN_W     = 7;
  localparam int BURST_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int LANES     = 8;
  localparam int DATA_W    = LANES * BYTE_W;
  localparam int S_TDATA_W = ((BURST_W + DATA_W + 7) / 8) * 8;
  localparam int M_PAY_W   = BURST_W + DATA_W + 2 * LEN_W;
  localparam int M_TDATA_W = ((M_PAY_W + 7) / 8) * 8;

  // Ring length after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);

  // Burst direction carried in the input tuser.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  // Result payload; the first member sits in the highest bits.
  typedef struct packed {
    logic [LEN_W-1:0]   used_count;
    logic [LEN_W-1:0]   free_count;
    logic [DATA_W-1:0]  read_bytes;
    logic [BURST_W-1:0] moved_count;
  } result_t;

endpackage

`default_nettype wire

// ----- design/brb_store.sv -----
// Banked byte store: one narrow memory per byte lane, one write and one read per bank a cycle.
`default_nettype none

module brb_store #(
  parameter int BANKS = 8,
  parameter int ROWS  = 8,
  localparam int ROW_W = $clog2(ROWS)
) (
  input  logic                                  clk,
  input  logic [BANKS-1:0]                      we,
  input  logic [BANKS-1:0][ROW_W-1:0]           waddr,
  input  logic [BANKS-1:0][brb_pkg::BYTE_W-1:0] wdata,
  input  logic                                  re,
  input  logic [BANKS-1:0][ROW_W-1:0]           raddr,
  output logic [BANKS-1:0][brb_pkg::BYTE_W-1:0] rdata
);
  import brb_pkg::*;

  // One memory per bank; read data is registered and held while no read is issued.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    logic [BYTE_W-1:0] mem [ROWS];

    always_ff @(posedge clk) begin
      if (we[b]) begin
        mem[waddr[b]] <= wdata[b];
      end
      if (re) begin
        rdata[b] <= mem[raddr[b]];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/byte_ring_buffer_burst.sv -----
// Top level of the byte ring buffer: burst decision, pointers, store and result pipeline.
`default_nettype none

// A byte ring buffer that takes one burst word per clock while the output side takes
// results: a write or a read of up to MAX_BURST bytes, carried out whole or refused
// whole. A write is taken only while more slots are free than it carries, so one slot
// of the ring always stays empty; a read is taken when at least as many bytes are
// stored. Every word in gives one word out with the outcome, the bytes read and the
// free and used counts after it. A word goes through two registers: the decision,
// pointer update and store access happen as the word is taken, and the bank read data
// are lined up into byte order in the next cycle. The store is split into MAX_BURST
// byte-wide banks, which lets a whole burst be written or read in a single access at
// any byte position. Writing the length register empties the ring at once; no clearing
// pass is needed after reset.
module byte_ring_buffer_burst #(
  parameter int STORE_DEPTH = 64,
  parameter int MAX_BURST   = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // Length register write port.
  input  logic                           cfg_we,
  input  logic [brb_pkg::LEN_W-1:0]      cfg_wdata,
  // Input burst words.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // burst_length [3:0], write_bytes [67:4], zero [71:68]
  input  logic [brb_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // opcode [0]
  input  logic                           s_axis_tuser,
  // Result words.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // moved_count [3:0], read_bytes [67:4], free_count [74:68], used_count [81:75], zero [87:82]
  output logic [brb_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // accepted [0]
  output logic                           m_axis_tuser
);
  import brb_pkg::*;

  localparam int BANKS    = MAX_BURST;
  localparam int ROWS_RAW = (STORE_DEPTH + MAX_BURST - 1) / MAX_BURST;
  localparam int ROWS     = (ROWS_RAW < 2) ? 2 : ROWS_RAW;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int BANK_W   = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int PHYS     = ROWS * BANKS;
  localparam int PHYS_W   = $clog2(PHYS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX =
    (STORE_DEPTH > (2 ** LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(STORE_DEPTH);
  localparam logic [BURST_W-1:0]  BURST_MAX = BURST_W'(MAX_BURST);
  localparam logic [BANK_W:0]     BANKS_EXT = (BANK_W + 1)'(BANKS);
  localparam logic [ROW_W-1:0]    ROW_LAST  = ROW_W'(ROWS - 1);

  // Registers
  logic [LEN_W-1:0]   cfg_len;
  logic [LEN_W-1:0]   used_cnt;
  logic [BANK_W-1:0]  wbank, rbank;
  logic [ROW_W-1:0]   wrow, rrow;
  logic               s1_valid, s1_acc, s1_read;
  logic [BURST_W-1:0] s1_len;
  logic [BANK_W-1:0]  s1_rbank;
  logic [LEN_W-1:0]   s1_free, s1_used;
  logic               out_valid, out_acc;
  result_t            out_res;

  // Combinational signals
  logic [LEN_W-1:0]   ring_len, free_now, len_ext, used_next, free_next;
  opcode_t            in_op;
  logic [BURST_W-1:0] in_len;
  logic [DATA_W-1:0]  in_wbytes;
  logic               s_acc, len_ok, item_ok, do_write, do_read, s1_move;
  logic [ROW_W-1:0]   wrow_inc, rrow_inc, wrow_next, rrow_next;
  logic [BANK_W-1:0]  wbank_next, rbank_next;
  logic [BANK_W:0]    wsum, rsum;
  logic [DATA_W-1:0]  rdata_s1;

  logic [BANKS-1:0]                  bank_we;
  logic [BANKS-1:0][ROW_W-1:0]       bank_waddr, bank_raddr;
  logic [BANKS-1:0][BYTE_W-1:0]      bank_wdata, bank_rdata;

  // Input word fields and the clamped ring length.
  assign in_op     = opcode_t'(s_axis_tuser);
  assign in_len    = s_axis_tdata[BURST_W-1:0];
  assign in_wbytes = s_axis_tdata[BURST_W +: DATA_W];
  assign len_ext   = LEN_W'(in_len);
  assign ring_len  = (cfg_len < LEN_MIN) ? LEN_MIN : ((cfg_len > LEN_MAX) ? LEN_MAX : cfg_len);
  assign free_now  = ring_len - used_cnt;

  // Handshake: the front moves when the middle stage is empty or moving on.
  assign s1_move       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // Burst decision.
  always_comb begin
    len_ok  = (in_len <= BURST_MAX);
    item_ok = 1'b0;
    unique case (in_op)
      OP_WRITE: item_ok = len_ok && (free_now > len_ext);
      OP_READ:  item_ok = len_ok && (used_cnt >= len_ext);
      default:  item_ok = 1'b0;
    endcase
  end

  assign do_write = s_acc && item_ok && (in_op == OP_WRITE);
  assign do_read  = s_acc && item_ok && (in_op == OP_READ);

  // Stored count after the word.
  always_comb begin
    priority if (do_write) begin
      used_next = used_cnt + len_ext;
    end else if (do_read) begin
      used_next = used_cnt - len_ext;
    end else begin
      used_next = used_cnt;
    end
  end
  assign free_next = ring_len - used_next;

  // Pointer advance over banks, carrying into the row on wrap.
  assign wrow_inc = (wrow == ROW_LAST) ? '0 : wrow + 1'b1;
  assign rrow_inc = (rrow == ROW_LAST) ? '0 : rrow + 1'b1;
  assign wsum     = (BANK_W + 1)'(wbank) + (BANK_W + 1)'(in_len);
  assign rsum     = (BANK_W + 1)'(rbank) + (BANK_W + 1)'(in_len);

  always_comb begin
    if (wsum >= BANKS_EXT) begin
      wbank_next = BANK_W'(wsum - BANKS_EXT);
      wrow_next  = wrow_inc;
    end else begin
      wbank_next = BANK_W'(wsum);
      wrow_next  = wrow;
    end
    if (rsum >= BANKS_EXT) begin
      rbank_next = BANK_W'(rsum - BANKS_EXT);
      rrow_next  = rrow_inc;
    end else begin
      rbank_next = BANK_W'(rsum);
      rrow_next  = rrow;
    end
  end

  // Per-bank addresses: banks below the start pointer take the next row.
  always_comb begin
    int lane;
    lane = 0;
    for (int b = 0; b < BANKS; b++) begin
      if (b >= int'(wbank)) begin
        lane          = b - int'(wbank);
        bank_waddr[b] = wrow;
      end else begin
        lane          = b + BANKS - int'(wbank);
        bank_waddr[b] = wrow_inc;
      end
      bank_we[b]    = do_write && (lane < int'(in_len));
      bank_wdata[b] = in_wbytes[lane * BYTE_W +: BYTE_W];
      bank_raddr[b] = (b >= int'(rbank)) ? rrow : rrow_inc;
    end
  end

  brb_store #(
    .BANKS (BANKS),
    .ROWS  (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (bank_we),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .re    (do_read),
    .raddr (bank_raddr),
    .rdata (bank_rdata)
  );

  // Length register and pointers; a length write empties the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_len  <= LEN_RESET;
      used_cnt <= '0;
      wbank    <= '0;
      wrow     <= '0;
      rbank    <= '0;
      rrow     <= '0;
    end else if (cfg_we) begin
      cfg_len  <= cfg_wdata;
      used_cnt <= '0;
      wbank    <= '0;
      wrow     <= '0;
      rbank    <= '0;
      rrow     <= '0;
    end else begin
      used_cnt <= used_next;
      if (do_write) begin
        wbank <= wbank_next;
        wrow  <= wrow_next;
      end
      if (do_read) begin
        rbank <= rbank_next;
        rrow  <= rrow_next;
      end
    end
  end

  // Middle stage: outcome of the word while the banks deliver read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_acc   <= item_ok;
      s1_read  <= do_read;
      s1_len   <= item_ok ? in_len : '0;
      s1_rbank <= rbank;
      s1_free  <= free_next;
      s1_used  <= used_next;
    end
  end

  // Rotate the bank outputs into byte order, clearing bytes past the burst.
  always_comb begin
    int src;
    src      = 0;
    rdata_s1 = '0;
    for (int i = 0; i < BANKS; i++) begin
      src = int'(s1_rbank) + i;
      if (src >= BANKS) begin
        src = src - BANKS;
      end
      if (s1_read && (i < int'(s1_len))) begin
        rdata_s1[i * BYTE_W +: BYTE_W] = bank_rdata[BANK_W'(src)];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_acc                <= s1_acc;
      out_res.moved_count    <= s1_len;
      out_res.read_bytes     <= rdata_s1;
      out_res.free_count     <= s1_free;
      out_res.used_count     <= s1_used;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_acc;
  assign m_axis_tdata  = {{(M_TDATA_W - M_PAY_W){1'b0}}, out_res};

  // Physical occupancy of the banked store, for checking against the stored count.
  logic [PHYS_W-1:0] wlin, rlin, occ;
  assign wlin = PHYS_W'(int'(wrow) * BANKS + int'(wbank));
  assign rlin = PHYS_W'(int'(rrow) * BANKS + int'(rbank));
  assign occ  = (wlin >= rlin) ? (wlin - rlin) : (PHYS_W'(PHYS) - (rlin - wlin));

  // The ring never fills its last slot.
  a_used_below_len: assert property (@(posedge clk) disable iff (rst)
    used_cnt < ring_len)
    else $error("stored count reached the ring length");

  // Store pointers agree with the stored count.
  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    int'(occ) == int'(used_cnt))
    else $error("store pointers disagree with stored count");

  // A stalled middle stage keeps its word and the bytes it has read.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_len) && $stable(s1_rbank)
      && $stable(rdata_s1))
    else $error("middle stage lost its word during a stall");

  // An accepted write adds exactly its length.
  a_write_count: assert property (@(posedge clk) disable iff (rst)
    do_write && !cfg_we |=> used_cnt == $past(used_cnt + len_ext))
    else $error("write did not add its burst length");

  // A refused word leaves the count alone.
  a_refuse_count: assert property (@(posedge clk) disable iff (rst)
    s_acc && !item_ok && !cfg_we |=> used_cnt == $past(used_cnt))
    else $error("refused burst changed the stored count");

endmodule

`default_nettype wire

// ----- dv/tb_byte_ring_buffer_burst.sv -----
`timescale 1ns / 100ps
// Testbench for the burst byte ring buffer: directed and random bursts checked against a predictor.
module tb_byte_ring_buffer_burst;
  import brb_pkg::*;

  localparam int RING_SLOTS    = 64;
  localparam int SLOT_W        = $clog2(RING_SLOTS);
  localparam int BURST_MAX     = 8;
  localparam int BURST_CODES   = (1 << BURST_W) - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;

  // Expected outcome of one burst: the tuser flag and the tdata payload.
  typedef struct packed {
    logic    accepted;
    result_t payload;
  } burst_outcome_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [LEN_W-1:0]     cfg_wdata     = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // burst_length [3:0], write_bytes [67:4], zero [71:68]
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  // opcode [0]
  logic                 s_axis_tuser  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // moved_count [3:0], read_bytes [67:4], free_count [74:68], used_count [81:75], zero [87:82]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // accepted [0]
  logic                 m_axis_tuser;

  // Predictor state: ring contents, pointers and the length register.
  logic [BYTE_W-1:0] ring_bytes [RING_SLOTS] = '{default: '0};
  int unsigned       rd_ptr = 0;
  int unsigned       wr_ptr = 0;
  logic [LEN_W-1:0]  length_setting = LEN_RESET;
  burst_outcome_t    pending_outcomes [$];

  bit          idle_en     = 1'b0;
  bit          write_heavy = 1'b0;
  int unsigned trend_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned errors      = 0;
  int unsigned cycle_count = 0;

  byte_ring_buffer_burst i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Ring size in use: the register value clamped to the legal range.
  function automatic int unsigned ring_size();
    if (length_setting < LEN_MIN) return 32'(LEN_MIN);
    if (length_setting > RING_SLOTS) return RING_SLOTS;
    return 32'(length_setting);
  endfunction

  function automatic int unsigned fill_level(int unsigned ring);
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring - (rd_ptr - wr_ptr);
  endfunction

  // Carries out one burst on the predictor state and returns the word it should produce.
  function automatic burst_outcome_t compute_burst_outcome(opcode_t op,
                                                          logic [BURST_W-1:0] count,
                                                          logic [DATA_W-1:0] wdata);
    int unsigned    ring;
    int unsigned    used;
    burst_outcome_t outcome;
    ring = ring_size();
    if (rd_ptr >= ring) rd_ptr = 0;
    if (wr_ptr >= ring) wr_ptr = 0;
    used = fill_level(ring);
    outcome = '0;
    // Overlong bursts fall straight through as refused.
    if (count <= BURST_MAX) begin
      if (op == OP_WRITE && ring - used > count) begin
        for (int i = 0; i < count; i++) begin
          ring_bytes[SLOT_W'(wr_ptr)] = wdata[BYTE_W*i +: BYTE_W];
          wr_ptr = (wr_ptr + 1 == ring) ? 0 : wr_ptr + 1;
        end
        outcome.accepted = 1'b1;
      end else if (op == OP_READ && used >= count) begin
        for (int i = 0; i < count; i++) begin
          outcome.payload.read_bytes[BYTE_W*i +: BYTE_W] = ring_bytes[SLOT_W'(rd_ptr)];
          rd_ptr = (rd_ptr + 1 == ring) ? 0 : rd_ptr + 1;
        end
        outcome.accepted = 1'b1;
      end
    end
    used = fill_level(ring);
    if (outcome.accepted) outcome.payload.moved_count = count;
    outcome.payload.free_count = LEN_W'(ring - used);
    outcome.payload.used_count = LEN_W'(used);
    return outcome;
  endfunction

  // Presents one burst word and holds it until the block takes it.
  task automatic push_burst(opcode_t op, logic [BURST_W-1:0] count, logic [DATA_W-1:0] wdata);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - BURST_W - DATA_W){1'b0}}, wdata, count};
    do @(posedge clk); while (!s_axis_tready);
    pending_outcomes.push_back(compute_burst_outcome(op, count, wdata));
  endtask

  task automatic pause_sender(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops sending and waits until every outstanding result word has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A length write also empties the ring, so it is only done with the block idle.
  task automatic set_ring_length(logic [LEN_W-1:0] value);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    length_setting = value;
    rd_ptr = 0;
    wr_ptr = 0;
  endtask

  // Random bursts in alternating write-heavy and read-heavy stretches, so the ring
  // swings between full and empty rather than hovering in the middle.
  task automatic send_random_bursts(int unsigned n_items);
    opcode_t            op;
    logic [BURST_W-1:0] count;
    int unsigned        cap;
    int unsigned        pick;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (trend_left == 0) begin
        write_heavy = !write_heavy;
        trend_left = $urandom_range(6, 40);
      end
      trend_left--;
      op = ($urandom_range(0, 99) < (write_heavy ? 75 : 25)) ? OP_WRITE : OP_READ;
      cap = (ring_size() < BURST_MAX) ? ring_size() : BURST_MAX;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        count = BURST_W'($urandom_range(BURST_MAX + 1, BURST_CODES));
      end else if (pick < 10) begin
        count = '0;
      end else begin
        count = BURST_W'($urandom_range(1, cap));
      end
      if (idle_en && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 13));
      push_burst(op, count, {$urandom, $urandom});
    end
  endtask

  // Zero-length, full-width, refused and overlong bursts at the reset length.
  task automatic test_basic_bursts();
    push_burst(OP_WRITE, 0, '0);
    push_burst(OP_READ, 0, '1);
    push_burst(OP_READ, 1, '0);
    push_burst(OP_WRITE, 8, '1);
    push_burst(OP_WRITE, 8, '0);
    push_burst(OP_WRITE, 4, {$urandom, $urandom});
    push_burst(OP_WRITE, BURST_W'(BURST_CODES), '1);
    push_burst(OP_READ, BURST_W'(BURST_MAX + 1), '0);
    push_burst(OP_READ, 8, '0);
    push_burst(OP_READ, 8, '0);
    push_burst(OP_READ, 4, '0);
    push_burst(OP_READ, 1, '0);
    push_burst(OP_READ, 0, '0);
  endtask

  // Smallest ring, then an out-of-range length filled to the one-empty-slot limit.
  task automatic test_length_limits();
    set_ring_length(LEN_MIN);
    push_burst(OP_WRITE, 2, {$urandom, $urandom});
    push_burst(OP_WRITE, 1, {$urandom, $urandom});
    push_burst(OP_WRITE, 1, {$urandom, $urandom});
    push_burst(OP_READ, 2, '0);
    push_burst(OP_READ, 1, '0);
    set_ring_length('1);
    repeat (7) push_burst(OP_WRITE, 8, {$urandom, $urandom});
    push_burst(OP_WRITE, 8, {$urandom, $urandom});
    push_burst(OP_WRITE, 7, {$urandom, $urandom});
  endtask

  task automatic test_random_traffic(logic [LEN_W-1:0] value, int unsigned n_items, bit idling);
    idle_en = idling;
    set_ring_length(value);
    send_random_bursts(n_items);
  endtask

  // Traffic with a full stop halfway: the sender holds off until every result is back.
  task automatic test_drain_pause(logic [LEN_W-1:0] value, int unsigned n_items);
    idle_en = 1'b1;
    set_ring_length(value);
    send_random_bursts(n_items / 2);
    wait_for_results();
    send_random_bursts(n_items - n_items / 2);
  endtask

  // Result side back-pressure: random stall bursts when enabled.
  always @(posedge clk) begin
    if (!idle_en) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 12);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compares each result word with the oldest outstanding expectation.
  always @(posedge clk) begin
    burst_outcome_t want;
    result_t        got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[M_PAY_W-1:0]);
      if (pending_outcomes.size() == 0) begin
        $error("result word with no burst outstanding");
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tuser !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, m_axis_tuser);
          errors++;
        end
        if (got.moved_count !== want.payload.moved_count) begin
          $error("moved_count: expected %0d, got %0d", want.payload.moved_count,
                 got.moved_count);
          errors++;
        end
        if (got.read_bytes !== want.payload.read_bytes) begin
          $error("read_bytes: expected %h, got %h", want.payload.read_bytes, got.read_bytes);
          errors++;
        end
        if (got.free_count !== want.payload.free_count) begin
          $error("free_count: expected %0d, got %0d", want.payload.free_count,
                 got.free_count);
          errors++;
        end
        if (got.used_count !== want.payload.used_count) begin
          $error("used_count: expected %0d, got %0d", want.payload.used_count,
                 got.used_count);
          errors++;
        end
      end
    end
  end

  // Test sequence; the last phase runs with no idling on either side.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    idle_en = 1'b1;
    test_basic_bursts();
    test_length_limits();
    test_random_traffic(LEN_RESET, 350, 1'b1);
    test_random_traffic(LEN_W'($urandom_range(0, 2)), 150, 1'b1);
    test_random_traffic(LEN_W'($urandom_range(3, 63)), 300, 1'b1);
    test_random_traffic(LEN_W'(8), 200, 1'b0);
    test_drain_pause(LEN_W'($urandom_range(65, 127)), 250);
    test_random_traffic(LEN_W'($urandom_range(3, 63)), 250, 1'b1);
    test_random_traffic(LEN_RESET, 350, 1'b0);
    wait_for_results();
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
